@@ rtl/epms_pkg.sv @@
// Package for the encoder PID motor speed controller.
// Holds the beat types, opcode and register index codes, sequencer states and datapath widths.
// Depends on nothing; every rtl file uses it.
package epms_pkg;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_EDGE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT = 3'd0,
      CSR_GAIN_P   = 3'd1,
      CSR_GAIN_I   = 3'd2,
      CSR_GAIN_D   = 3'd3,
      CSR_PPR      = 3'd4,
      CSR_TICK_MS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      opcode_type opcode;
      logic       encoder_b;
   } req_type;

   typedef struct packed {
      logic [7:0]         pwm_forward;
      logic [7:0]         pwm_reverse;
      logic               drive_enable;
      logic signed [15:0] measured_rpm;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NUM,
      ST_MUL_DEN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SAT,
      ST_ERR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_FINISH,
      ST_DONE
   } state_type;

   // Datapath widths.
   localparam int MUL_A_W   = 18;  // signed operand: count, error, integral or difference
   localparam int MUL_B_W   = 17;  // signed operand holding an unsigned gain or constant
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 36;  // sum of the three PID products
   localparam int NUM_W     = 32;  // signed 60000 * count
   localparam int DIV_NUM_W = 31;  // magnitude of that product
   localparam int DEN_W     = 22;  // pulses_per_rev * tick_ms
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam int ERR_W     = 16;
   localparam int SUM_W     = 14;

   localparam int MS_PER_MINUTE = 60000;
   localparam int SUM_LIMIT     = 5000;
   localparam int DUTY_LIMIT    = 255;
   localparam int CMD_SHIFT     = 8;

endpackage

@@ rtl/epms_div.sv @@
// Restoring divider for the speed measurement, one quotient bit per cycle.
// Depends on epms_pkg for the dividend, divisor and counter widths.
module epms_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [epms_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [epms_pkg::DEN_W-1:0]      divisor,
   output logic                            done,
   output logic [epms_pkg::DIV_NUM_W-1:0]  quotient
);

   logic [epms_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [epms_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [epms_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [epms_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;

   logic [epms_pkg::DEN_W:0]       shifted;
   logic [epms_pkg::DEN_W+1:0]     trial;

   assign shifted = {rem_ff, quo_ff[epms_pkg::DIV_NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         den_in = divisor;
         quo_in = dividend;
         cnt_in = epms_pkg::DIV_CNT_W'(epms_pkg::DIV_NUM_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         // The borrow bit of the trial subtraction decides the quotient bit.
         if (!trial[epms_pkg::DEN_W+1]) begin
            rem_in = trial[epms_pkg::DEN_W-1:0];
            quo_in = {quo_ff[epms_pkg::DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[epms_pkg::DEN_W-1:0];
            quo_in = {quo_ff[epms_pkg::DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/encoder_pid_motor_speed.sv @@
// Top level of the encoder PID motor speed controller: sequencer, shared multiplier, state.
// Depends on epms_pkg and instantiates the serial divider epms_div.
//
// Each request beat is an encoder edge, a control tick or a clear command, and each one
// produces exactly one response beat that shows the drive outputs after that beat. The
// block works on one beat at a time and holds req_stall high while it is busy. An edge,
// a clear command or the unused opcode goes from idle straight to the done state, which
// writes the response register once it is free. For a tick, one shared 18 by 17 bit signed
// multiplier forms the numerator 60000 * count and the divisor pulses_per_rev * tick_ms, a
// restoring divider then produces the speed one quotient bit at a time, and the same
// multiplier forms the three PID products before they are summed, shifted, clamped and
// steered to the forward or reverse duty. A finished response sits in an output register,
// so a new request is accepted as soon as the sequencer is idle even if the previous
// response has not been taken yet.
// Configuration writes must only be made while the block is idle.
module encoder_pid_motor_speed (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  epms_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output epms_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [epms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [epms_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Configuration registers.
   logic signed [14:0] setpoint_ff, setpoint_in;
   logic [15:0]        gain_p_ff, gain_p_in;
   logic [15:0]        gain_i_ff, gain_i_in;
   logic [15:0]        gain_d_ff, gain_d_in;
   logic [11:0]        ppr_ff, ppr_in;
   logic [9:0]         tick_ms_ff, tick_ms_in;

   // Controller state.
   logic signed [15:0]                  pulse_count_ff, pulse_count_in;
   logic signed [epms_pkg::SUM_W-1:0]   error_sum_ff, error_sum_in;
   logic signed [epms_pkg::ERR_W-1:0]   last_error_ff, last_error_in;
   logic signed [15:0]                  speed_now_ff, speed_now_in;
   logic [7:0]                          duty_fwd_ff, duty_fwd_in;
   logic [7:0]                          duty_rev_ff, duty_rev_in;
   logic                                enable_ff, enable_in;

   // Tick datapath.
   logic signed [epms_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [epms_pkg::DIV_NUM_W-1:0]      mag_ff, mag_in;
   logic                                neg_ff, neg_in;
   logic [epms_pkg::DEN_W-1:0]          den_ff, den_in;
   logic signed [epms_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [epms_pkg::ERR_W:0]     diff_ff, diff_in;
   logic signed [epms_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [epms_pkg::ACC_W-1:0]   acc_ff, acc_in;

   // Sequencer and response register.
   epms_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   epms_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // Shared multiplier.
   logic signed [epms_pkg::MUL_A_W-1:0] mul_a;
   logic signed [epms_pkg::MUL_B_W-1:0] mul_b;
   logic signed [epms_pkg::PROD_W-1:0]  prod;

   // Divider handshake.
   logic                                div_start;
   logic                                div_done;
   logic [epms_pkg::DIV_NUM_W-1:0]      div_quo;

   // Helpers.
   logic                                accept;
   logic                                rsp_free;
   logic [11:0]                         ppr_eff;
   logic [9:0]                          ms_eff;
   logic [epms_pkg::NUM_W-1:0]          num_abs;
   logic signed [epms_pkg::ERR_W:0]     err_wide;
   logic signed [epms_pkg::ACC_W-1:0]   cmd_wide;
   logic signed [epms_pkg::ERR_W:0]     sum_wide;

   assign req_stall = (state_ff != epms_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign ppr_eff  = (ppr_ff == '0) ? 12'd1 : ppr_ff;
   assign ms_eff   = (tick_ms_ff == '0) ? 10'd1 : tick_ms_ff;
   assign num_abs  = num_ff[epms_pkg::NUM_W-1] ? epms_pkg::NUM_W'(-num_ff) : num_ff;
   assign err_wide = (epms_pkg::ERR_W+1)'(setpoint_ff) - (epms_pkg::ERR_W+1)'(speed_now_ff);
   assign cmd_wide = acc_ff >>> epms_pkg::CMD_SHIFT;
   assign sum_wide = (epms_pkg::ERR_W+1)'(error_sum_ff) + (epms_pkg::ERR_W+1)'(err_ff);

   assign prod = epms_pkg::PROD_W'(mul_a) * epms_pkg::PROD_W'(mul_b);

   epms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         epms_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == epms_pkg::OP_TICK) begin
                  state_in = epms_pkg::ST_MUL_NUM;
               end else begin
                  state_in = epms_pkg::ST_DONE;
               end
            end
         end
         epms_pkg::ST_MUL_NUM:  state_in = epms_pkg::ST_MUL_DEN;
         epms_pkg::ST_MUL_DEN:  state_in = epms_pkg::ST_DIV_GO;
         epms_pkg::ST_DIV_GO:   state_in = epms_pkg::ST_DIV_WAIT;
         epms_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = epms_pkg::ST_SAT;
            end
         end
         epms_pkg::ST_SAT:      state_in = epms_pkg::ST_ERR;
         epms_pkg::ST_ERR:      state_in = epms_pkg::ST_MUL_P;
         epms_pkg::ST_MUL_P:    state_in = epms_pkg::ST_MUL_I;
         epms_pkg::ST_MUL_I:    state_in = epms_pkg::ST_MUL_D;
         epms_pkg::ST_MUL_D:    state_in = epms_pkg::ST_ACC;
         epms_pkg::ST_ACC:      state_in = epms_pkg::ST_FINISH;
         epms_pkg::ST_FINISH:   state_in = epms_pkg::ST_DONE;
         epms_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = epms_pkg::ST_IDLE;
            end
         end
         default:               state_in = epms_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and register updates.
   always_comb begin
      setpoint_in    = setpoint_ff;
      gain_p_in      = gain_p_ff;
      gain_i_in      = gain_i_ff;
      gain_d_in      = gain_d_ff;
      ppr_in         = ppr_ff;
      tick_ms_in     = tick_ms_ff;
      pulse_count_in = pulse_count_ff;
      error_sum_in   = error_sum_ff;
      last_error_in  = last_error_ff;
      speed_now_in   = speed_now_ff;
      duty_fwd_in    = duty_fwd_ff;
      duty_rev_in    = duty_rev_ff;
      enable_in      = enable_ff;
      num_in         = num_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      den_in         = den_ff;
      err_in         = err_ff;
      diff_in        = diff_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      div_start      = 1'b0;
      mul_a          = '0;
      mul_b          = '0;

      unique case (state_ff)
         epms_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.opcode)
                  epms_pkg::OP_EDGE: begin
                     // Channel B low counts up, high counts down; both ends saturate.
                     if (!req_data.encoder_b) begin
                        if (pulse_count_ff != 16'sh7FFF) begin
                           pulse_count_in = pulse_count_ff + 16'sd1;
                        end
                     end else begin
                        if (pulse_count_ff != 16'sh8000) begin
                           pulse_count_in = pulse_count_ff - 16'sd1;
                        end
                     end
                  end
                  epms_pkg::OP_CLEAR: begin
                     pulse_count_in = '0;
                     error_sum_in   = '0;
                     last_error_in  = '0;
                     speed_now_in   = '0;
                     duty_fwd_in    = '0;
                     duty_rev_in    = '0;
                     enable_in      = 1'b0;
                     setpoint_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         epms_pkg::ST_MUL_NUM: begin
            mul_a          = epms_pkg::MUL_A_W'(pulse_count_ff);
            mul_b          = epms_pkg::MUL_B_W'(epms_pkg::MS_PER_MINUTE);
            num_in         = prod[epms_pkg::NUM_W-1:0];
            pulse_count_in = '0;
         end
         epms_pkg::ST_MUL_DEN: begin
            mul_a  = {6'd0, ppr_eff};
            mul_b  = {7'd0, ms_eff};
            den_in = prod[epms_pkg::DEN_W-1:0];
            mag_in = num_abs[epms_pkg::DIV_NUM_W-1:0];
            neg_in = num_ff[epms_pkg::NUM_W-1];
         end
         epms_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
         end
         epms_pkg::ST_DIV_WAIT: begin
         end
         epms_pkg::ST_SAT: begin
            // The quotient magnitude is truncated toward zero; restore the sign and saturate.
            if (neg_ff) begin
               if (div_quo > epms_pkg::DIV_NUM_W'(32768)) begin
                  speed_now_in = 16'sh8000;
               end else begin
                  speed_now_in = -div_quo[15:0];
               end
            end else begin
               if (div_quo > epms_pkg::DIV_NUM_W'(32767)) begin
                  speed_now_in = 16'sh7FFF;
               end else begin
                  speed_now_in = div_quo[15:0];
               end
            end
         end
         epms_pkg::ST_ERR: begin
            if (err_wide > 17'sd32767) begin
               err_in = 16'sh7FFF;
            end else if (err_wide < -17'sd32768) begin
               err_in = 16'sh8000;
            end else begin
               err_in = err_wide[epms_pkg::ERR_W-1:0];
            end
         end
         epms_pkg::ST_MUL_P: begin
            mul_a   = epms_pkg::MUL_A_W'(err_ff);
            mul_b   = {1'b0, gain_p_ff};
            prod_in = prod;
            diff_in = (epms_pkg::ERR_W+1)'(err_ff) - (epms_pkg::ERR_W+1)'(last_error_ff);
         end
         epms_pkg::ST_MUL_I: begin
            // The integral term uses the sum from before this tick.
            mul_a   = epms_pkg::MUL_A_W'(error_sum_ff);
            mul_b   = {1'b0, gain_i_ff};
            prod_in = prod;
            acc_in  = epms_pkg::ACC_W'(prod_ff);
         end
         epms_pkg::ST_MUL_D: begin
            mul_a   = epms_pkg::MUL_A_W'(diff_ff);
            mul_b   = {1'b0, gain_d_ff};
            prod_in = prod;
            acc_in  = acc_ff + epms_pkg::ACC_W'(prod_ff);
         end
         epms_pkg::ST_ACC: begin
            acc_in = acc_ff + epms_pkg::ACC_W'(prod_ff);
         end
         epms_pkg::ST_FINISH: begin
            // The arithmetic shift is a floor division by 256.
            if (cmd_wide > epms_pkg::ACC_W'(epms_pkg::DUTY_LIMIT)) begin
               duty_fwd_in = 8'(epms_pkg::DUTY_LIMIT);
               duty_rev_in = '0;
            end else if (cmd_wide < epms_pkg::ACC_W'(-epms_pkg::DUTY_LIMIT)) begin
               duty_fwd_in = '0;
               duty_rev_in = 8'(epms_pkg::DUTY_LIMIT);
            end else if (cmd_wide > epms_pkg::ACC_W'(0)) begin
               duty_fwd_in = cmd_wide[7:0];
               duty_rev_in = '0;
            end else begin
               duty_fwd_in = '0;
               duty_rev_in = -cmd_wide[7:0];
            end
            last_error_in = err_ff;
            if (sum_wide > (epms_pkg::ERR_W+1)'(epms_pkg::SUM_LIMIT)) begin
               error_sum_in = epms_pkg::SUM_W'(epms_pkg::SUM_LIMIT);
            end else if (sum_wide < (epms_pkg::ERR_W+1)'(-epms_pkg::SUM_LIMIT)) begin
               error_sum_in = epms_pkg::SUM_W'(-epms_pkg::SUM_LIMIT);
            end else begin
               error_sum_in = sum_wide[epms_pkg::SUM_W-1:0];
            end
            enable_in = 1'b1;
         end
         epms_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.pwm_forward  = duty_fwd_ff;
               rsp_data_in.pwm_reverse  = duty_rev_ff;
               rsp_data_in.drive_enable = enable_ff;
               rsp_data_in.measured_rpm = speed_now_ff;
            end
         end
         default: begin
         end
      endcase

      // Register writes must only arrive while the sequencer is idle; the block itself does not enforce this.
      if (csr_write) begin
         unique case (epms_pkg::csr_index_type'(csr_index))
            epms_pkg::CSR_SETPOINT: setpoint_in = csr_data[14:0];
            epms_pkg::CSR_GAIN_P:   gain_p_in   = csr_data;
            epms_pkg::CSR_GAIN_I:   gain_i_in   = csr_data;
            epms_pkg::CSR_GAIN_D:   gain_d_in   = csr_data;
            epms_pkg::CSR_PPR:      ppr_in      = csr_data[11:0];
            epms_pkg::CSR_TICK_MS:  tick_ms_in  = csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= epms_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         setpoint_ff    <= '0;
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         ppr_ff         <= 12'd1;
         tick_ms_ff     <= 10'd10;
         pulse_count_ff <= '0;
         error_sum_ff   <= '0;
         last_error_ff  <= '0;
         speed_now_ff   <= '0;
         duty_fwd_ff    <= '0;
         duty_rev_ff    <= '0;
         enable_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         setpoint_ff    <= setpoint_in;
         gain_p_ff      <= gain_p_in;
         gain_i_ff      <= gain_i_in;
         gain_d_ff      <= gain_d_in;
         ppr_ff         <= ppr_in;
         tick_ms_ff     <= tick_ms_in;
         pulse_count_ff <= pulse_count_in;
         error_sum_ff   <= error_sum_in;
         last_error_ff  <= last_error_in;
         speed_now_ff   <= speed_now_in;
         duty_fwd_ff    <= duty_fwd_in;
         duty_rev_ff    <= duty_rev_in;
         enable_ff      <= enable_in;
      end
      num_ff      <= num_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      den_ff      <= den_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
